// ===== rtl/ffha_pkg.sv =====
// Package for the first-fit heap allocator: sizes, status codes, table entry type.
// No dependencies.
`timescale 1ns / 1ps
package ffha_pkg;
	localparam int MaxBlocks   = 32;
	localparam int HeaderBytes = 16;
	localparam int AddrBits    = 16;
	localparam int IdxBits     = $clog2(MaxBlocks);
	localparam int CntBits     = $clog2(MaxBlocks + 1);
	// header address and length carry one spare bit so sums do not wrap
	localparam int LenBits     = 17;
	localparam logic [16:0] HeapReset = 17'd50000;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_NO_FIT     = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND  = 2'd2;
	localparam logic [1:0] ST_TABLE_FULL = 2'd3;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	typedef struct packed {
		logic [LenBits-1:0] hdr;
		logic [LenBits-1:0] len;
		logic               used;
	} entry_t;

	// controller -> datapath
	typedef struct packed {
		logic init;      // candidate index to zero
		logic load_req;  // capture request
		logic scan_clr;  // index to zero
		logic scan_end;  // index to count
		logic scan_inc;  // index + 1
		logic scan_dec;  // index - 1
		logic grab;      // capture entry at index as candidate
		logic wr_split;  // write split pieces, count + 1
		logic shift_up;
		logic shift_dn;
		logic wr_cand;   // write candidate back at cand index
		logic merge_chk; // capture merge of cand with next
		logic set_res;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic at_end;     // index >= count
		logic hit;        // entry at index matches the search
		logic split_need;
		logic full;
		logic can_merge;
		logic shup_done;  // up shift reached cand + 1
		logic shdn_done;  // down shift reached the last entry
		logic cand_zero;
	} stat_t;
endpackage

// ===== rtl/ffha_if.sv =====
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing.
`timescale 1ns / 1ps
interface ffha_req_if;
	logic        valid;
	logic        ready;
	logic        op;
	logic [15:0] request_value;
	modport source (output valid, op, request_value, input ready);
	modport sink (input valid, op, request_value, output ready);
endinterface

interface ffha_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [15:0] block_address;
	logic        heap_empty;
	modport source (output valid, status, block_address, heap_empty, input ready);
	modport sink (input valid, status, block_address, heap_empty, output ready);
endinterface

// ===== rtl/ffha_datapath.sv =====
// Datapath: block table registers, scan index, candidate entry, result registers.
// Depends on ffha_pkg.
`timescale 1ns / 1ps
module ffha_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ffha_pkg::cmd_t       cmd,
	output ffha_pkg::stat_t      stat,
	input  logic                 cfg_we,
	input  logic [15:0]          cfg_data,
	input  logic                 req_op,
	input  logic [15:0]          req_value,
	output logic [1:0]           res_status,
	output logic [15:0]          res_addr,
	output logic                 res_empty,
	input  logic [1:0]           set_status
);
	localparam int LB = ffha_pkg::LenBits;
	localparam int IB = ffha_pkg::IdxBits;
	localparam int CB = ffha_pkg::CntBits;

	ffha_pkg::entry_t tbl_q [ffha_pkg::MaxBlocks];
	logic [CB-1:0] cnt_q;
	logic [CB-1:0] idx_q;     // scan index; also shift pointer
	logic [IB-1:0] cand_q;
	ffha_pkg::entry_t cent_q;
	logic          op_q;
	logic [15:0]   val_q;
	logic [CB-1:0] used_q;    // number of allocated blocks

	ffha_pkg::entry_t cur, nxt;
	logic [LB:0] need, rest, hsum;
	logic [IB-1:0] idx_i, cand_n;

	always_comb begin
		idx_i = idx_q[IB-1:0];
		cur = tbl_q[idx_i];
		cand_n = cand_q + IB'(1);
		nxt = tbl_q[cand_n];
		need = {1'b0, 1'b0, val_q} + (LB+1)'(ffha_pkg::HeaderBytes);
		rest = {1'b0, cent_q.len} - need;
		hsum = {1'b0, cent_q.hdr} + (LB+1)'(ffha_pkg::HeaderBytes)
			+ {1'b0, cent_q.len};
		stat.at_end = idx_q >= cnt_q;
		if (op_q == ffha_pkg::OP_ALLOC)
			stat.hit = !cur.used && ({1'b0, cur.len} >= need)
				&& ({1'b0, cur.hdr} + (LB+1)'(ffha_pkg::HeaderBytes)
				<= (LB+1)'((1 << ffha_pkg::AddrBits) - 1));
		else
			stat.hit = cur.used && ({1'b0, cur.hdr} + (LB+1)'(ffha_pkg::HeaderBytes)
				== {2'b0, val_q});
		stat.split_need = ({1'b0, cent_q.len} >= need)
			&& (rest >= (LB+1)'(ffha_pkg::HeaderBytes));
		stat.full = cnt_q >= CB'(ffha_pkg::MaxBlocks);
		stat.can_merge = ({1'b0, cand_q} + CB'(1) < cnt_q) && !cent_q.used
			&& !nxt.used && (hsum == {1'b0, nxt.hdr});
		stat.shup_done = idx_q <= {1'b0, cand_q} + CB'(1);
		stat.shdn_done = idx_q + CB'(1) >= cnt_q;
		stat.cand_zero = cand_q == '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= CB'(1);
			idx_q  <= '0;
			used_q <= '0;
			for (int i = 1; i < ffha_pkg::MaxBlocks; i++) tbl_q[i] <= '0;
			tbl_q[0] <= {LB'(0), ffha_pkg::HeapReset, 1'b0};
		end else begin
			if (cfg_we) begin
				cnt_q  <= CB'(1);
				used_q <= '0;
				tbl_q[0] <= {LB'(0), 1'b0, cfg_data, 1'b0};
			end
			if (cmd.scan_clr) idx_q <= '0;
			if (cmd.scan_end) idx_q <= cnt_q;
			if (cmd.scan_inc) idx_q <= idx_q + CB'(1);
			if (cmd.scan_dec) idx_q <= idx_q - CB'(1);
			if (cmd.shift_up) begin
				// move entry idx-1 into idx, walking down
				tbl_q[idx_i] <= tbl_q[idx_i - IB'(1)];
				idx_q <= idx_q - CB'(1);
			end
			if (cmd.shift_dn) begin
				tbl_q[idx_i] <= tbl_q[idx_i + IB'(1)];
				idx_q <= idx_q + CB'(1);
				if (idx_q + CB'(1) >= cnt_q) cnt_q <= cnt_q - CB'(1);
			end
			if (cmd.wr_split) begin
				tbl_q[cand_q] <= {cent_q.hdr, 1'b0, val_q, 1'b1};
				tbl_q[cand_n] <= {LB'(cent_q.hdr + need[LB-1:0]), rest[LB-1:0], 1'b0};
				cnt_q  <= cnt_q + CB'(1);
				used_q <= used_q + CB'(1);
			end
			if (cmd.wr_cand) begin
				tbl_q[cand_q] <= cent_q;
				if (op_q == ffha_pkg::OP_ALLOC) used_q <= used_q + CB'(1);
				else used_q <= used_q - CB'(1);
			end
			if (cmd.merge_chk) begin
				// absorb next into cand; shift removes it
				tbl_q[cand_q].len <= LB'(hsum[LB-1:0] - cent_q.hdr + nxt.len);
				idx_q <= {1'b0, cand_n};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			op_q  <= req_op;
			val_q <= req_value;
		end
		if (cmd.grab) begin
			cand_q <= idx_i;
			cent_q <= {cur.hdr, cur.len, op_q == ffha_pkg::OP_ALLOC};
		end
		if (cmd.init) cand_q <= '0;
		if (cmd.scan_dec && !cmd.grab) begin
			cand_q <= cand_q - IB'(1);
			cent_q <= tbl_q[cand_q - IB'(1)];
		end
		if (cmd.merge_chk) cent_q.len <= LB'(hsum[LB-1:0] - cent_q.hdr + nxt.len);
		if (cmd.set_res) begin
			res_status <= set_status;
			res_addr   <= (set_status == ffha_pkg::ST_OK) ?
				((op_q == ffha_pkg::OP_ALLOC) ? 16'(cent_q.hdr + LB'(ffha_pkg::HeaderBytes))
				: val_q) : 16'd0;
			res_empty  <= used_q == '0;
		end
	end
endmodule

// ===== rtl/ffha_ctrl.sv =====
// Controller state machine sequencing scan, split, shift and merge steps.
// Depends on ffha_pkg.
`timescale 1ns / 1ps
module ffha_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             in_op,
	output logic             out_valid,
	input  logic             out_ready,
	output ffha_pkg::cmd_t   cmd,
	input  ffha_pkg::stat_t  stat,
	output logic [1:0]       set_status
);
	localparam logic [3:0] S_IDLE = 4'd0, S_SCAN = 4'd1, S_SHUP = 4'd2,
		S_SPLIT = 4'd3, S_MRG = 4'd4, S_SHDN = 4'd5, S_PREV = 4'd6,
		S_DONE = 4'd7, S_WRC = 4'd8, S_MRG2 = 4'd9;
	logic [3:0] st_q, st_n;
	logic       op_q, prev_q, prev_n, ov_q, ov_n;
	logic [1:0] sts_q, sts_n;

	assign in_ready  = (st_q == S_IDLE) && (!ov_q || out_ready);
	assign out_valid = ov_q;
	assign set_status = sts_n;

	always_comb begin
		cmd = '0;
		st_n = st_q;
		sts_n = sts_q;
		prev_n = prev_q;
		ov_n = ov_q && !out_ready;
		case (st_q)
			S_IDLE: begin
				if (in_valid && in_ready) begin
					cmd.load_req = 1'b1;
					cmd.scan_clr = 1'b1;
					st_n = S_SCAN;
				end
			end
			S_SCAN: begin
				if (stat.at_end) begin
					sts_n = (op_q == ffha_pkg::OP_ALLOC) ? ffha_pkg::ST_NO_FIT
						: ffha_pkg::ST_NOT_FOUND;
					st_n = S_DONE;
				end else if (stat.hit) begin
					cmd.grab = 1'b1;
					st_n = S_WRC;
				end else cmd.scan_inc = 1'b1;
			end
			S_WRC: begin
				sts_n = ffha_pkg::ST_OK;
				if (op_q == ffha_pkg::OP_ALLOC && stat.split_need) begin
					if (stat.full) begin
						sts_n = ffha_pkg::ST_TABLE_FULL;
						st_n = S_DONE;
					end else begin
						cmd.scan_end = 1'b1;
						st_n = S_SHUP;
					end
				end else begin
					cmd.wr_cand = 1'b1;
					prev_n = 1'b0;
					st_n = (op_q == ffha_pkg::OP_ALLOC) ? S_DONE : S_MRG;
				end
			end
			S_SHUP: begin
				// idx sits at count; copy down to cand+2
				if (stat.shup_done) st_n = S_SPLIT;
				else cmd.shift_up = 1'b1;
			end
			S_SPLIT: begin
				cmd.wr_split = 1'b1;
				st_n = S_DONE;
			end
			S_MRG: begin
				if (stat.can_merge) begin
					cmd.merge_chk = 1'b1;
					st_n = S_SHDN;
				end else st_n = S_PREV;
			end
			S_SHDN: begin
				cmd.shift_dn = 1'b1;
				if (stat.shdn_done) st_n = S_PREV;
			end
			S_PREV: begin
				if (!prev_q && !stat.cand_zero) begin
					cmd.scan_dec = 1'b1;
					prev_n = 1'b1;
					st_n = S_MRG2;
				end else st_n = S_DONE;
			end
			S_MRG2: st_n = S_MRG;
			S_DONE: begin
				if (!ov_q || out_ready) begin
					cmd.set_res = 1'b1;
					ov_n = 1'b1;
					st_n = S_IDLE;
				end
			end
			default: st_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			op_q <= 1'b0;
			prev_q <= 1'b0;
			ov_q <= 1'b0;
			sts_q <= ffha_pkg::ST_OK;
		end else begin
			st_q <= st_n;
			prev_q <= prev_n;
			ov_q <= ov_n;
			sts_q <= sts_n;
			if (cmd.load_req) op_q <= in_op;
		end
	end
endmodule

// ===== rtl/first_fit_heap_allocator.sv =====
// First-fit heap allocator with coalescing.
// Channel "req" (sink): op 0 allocate request_value bytes, op 1 free payload
// address request_value. Channel "rsp" (source): status, block_address,
// heap_empty; one response per request.
// heap_size is written by cfg_we/cfg_data and rebuilds the table as one free
// block; write it only while idle.
// Work per request: a scan of the block table at one entry per cycle, plus up
// to one shift pass of the table for a split or each merge. One request is
// worked at a time; the next is accepted at the earliest in the same cycle the
// response is offered, so the table walk sets the rate.
// Reset: table holds one free block of 50000 bytes at address 0.
// A stalled response is held in its register; the next request is accepted
// once the response is taken or in the same cycle it is taken.
// Depends on ffha_pkg, ffha_if, ffha_ctrl, ffha_datapath.
`timescale 1ns / 1ps
module first_fit_heap_allocator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_data,
	ffha_req_if.sink    req,
	ffha_rsp_if.source  rsp
);
	ffha_pkg::cmd_t  cmd;
	ffha_pkg::stat_t stat;
	logic [1:0] set_status;

	ffha_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(req.valid), .in_ready(req.ready), .in_op(req.op),
		.out_valid(rsp.valid), .out_ready(rsp.ready),
		.cmd, .stat, .set_status
	);

	ffha_datapath u_dp (
		.clk, .arst_n, .cmd, .stat, .cfg_we, .cfg_data,
		.req_op(req.op), .req_value(req.request_value),
		.res_status(rsp.status), .res_addr(rsp.block_address),
		.res_empty(rsp.heap_empty), .set_status
	);
endmodule

// ===== tb/sv/tb_heap_ledger.sv =====
// Scoreboard for the first-fit heap allocator: shadow block table and response queue.
// Depends on ffha_pkg.
`timescale 1ns / 1ps
package tb_heap_ledger_pkg;
	typedef struct {
		logic [1:0]  status;
		logic [15:0] block_address;
		logic        heap_empty;
	} heap_rsp_t;

	class heap_ledger;
		longint unsigned blk_hdr[ffha_pkg::MaxBlocks];
		longint unsigned blk_len[ffha_pkg::MaxBlocks];
		bit              blk_used[ffha_pkg::MaxBlocks];
		int              n_blocks;
		longint unsigned heap_bytes;
		heap_rsp_t       pending[$];
		int              errors;

		function new();
			errors = 0;
			rebuild(50000);
		endfunction

		function void rebuild(longint unsigned size);
			heap_bytes = size;
			foreach (blk_hdr[i]) begin
				blk_hdr[i] = 0; blk_len[i] = 0; blk_used[i] = 0;
			end
			blk_len[0] = size;
			n_blocks = 1;
		endfunction

		function void drop_at(int i);
			for (int k = i; k + 1 < n_blocks; k++) begin
				blk_hdr[k] = blk_hdr[k+1]; blk_len[k] = blk_len[k+1];
				blk_used[k] = blk_used[k+1];
			end
			n_blocks--;
		endfunction

		function void open_at(int i);
			for (int k = n_blocks; k > i; k--) begin
				blk_hdr[k] = blk_hdr[k-1]; blk_len[k] = blk_len[k-1];
				blk_used[k] = blk_used[k-1];
			end
			n_blocks++;
		endfunction

		function void merge_next(int i);
			if (i + 1 >= n_blocks) return;
			if (blk_used[i] || blk_used[i+1]) return;
			if (blk_hdr[i] + ffha_pkg::HeaderBytes + blk_len[i] != blk_hdr[i+1]) return;
			blk_len[i] = blk_len[i] + ffha_pkg::HeaderBytes + blk_len[i+1];
			drop_at(i + 1);
		endfunction

		function heap_rsp_t allocate(longint unsigned bytes);
			heap_rsp_t r;
			longint unsigned need;
			int i;
			need = bytes + ffha_pkg::HeaderBytes;
			r.status = ffha_pkg::ST_NO_FIT;
			r.block_address = 0;
			for (i = 0; i < n_blocks; i++)
				if (!blk_used[i] && blk_len[i] >= need
					&& blk_hdr[i] + ffha_pkg::HeaderBytes <= 65535)
					break;
			if (i < n_blocks) begin
				r.status = ffha_pkg::ST_OK;
				if (blk_len[i] - need >= ffha_pkg::HeaderBytes) begin
					if (n_blocks >= ffha_pkg::MaxBlocks) r.status = ffha_pkg::ST_TABLE_FULL;
					else begin
						open_at(i + 1);
						blk_hdr[i+1] = blk_hdr[i] + need;
						blk_len[i+1] = blk_len[i] - need;
						blk_used[i+1] = 0;
						blk_len[i] = bytes;
					end
				end
				if (r.status == ffha_pkg::ST_OK) begin
					blk_used[i] = 1;
					r.block_address = 16'(blk_hdr[i] + ffha_pkg::HeaderBytes);
				end
			end
			return r;
		endfunction

		function heap_rsp_t release_at(longint unsigned where);
			heap_rsp_t r;
			int i;
			r.status = ffha_pkg::ST_NOT_FOUND;
			r.block_address = 0;
			for (i = 0; i < n_blocks; i++)
				if (blk_used[i] && blk_hdr[i] + ffha_pkg::HeaderBytes == where) break;
			if (i < n_blocks) begin
				blk_used[i] = 0;
				merge_next(i);
				if (i > 0) merge_next(i - 1);
				r.status = ffha_pkg::ST_OK;
				r.block_address = 16'(where);
			end
			return r;
		endfunction

		// note an accepted request and queue its expected response
		function void note_request(logic op, logic [15:0] val);
			heap_rsp_t r;
			r = (op == ffha_pkg::OP_ALLOC) ? allocate(val) : release_at(val);
			r.heap_empty = 1;
			for (int i = 0; i < n_blocks; i++) if (blk_used[i]) r.heap_empty = 0;
			pending.push_back(r);
		endfunction

		function void check_response(logic [1:0] st, logic [15:0] addr, logic empty);
			heap_rsp_t e;
			if (pending.size() == 0) begin
				$error("unexpected response status=%0d addr=%0d", st, addr);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (st !== e.status) begin
				$error("status expected %0d actual %0d", e.status, st); errors++;
			end
			if (addr !== e.block_address) begin
				$error("block_address expected %0d actual %0d", e.block_address, addr);
				errors++;
			end
			if (empty !== e.heap_empty) begin
				$error("heap_empty expected %0d actual %0d", e.heap_empty, empty); errors++;
			end
		endfunction

		// pick a live payload address, or 0 if none
		function logic [15:0] live_address();
			int idx[$];
			for (int i = 0; i < n_blocks; i++) if (blk_used[i]) idx.push_back(i);
			if (idx.size() == 0) return 0;
			return 16'(blk_hdr[idx[$urandom_range(idx.size() - 1)]] + ffha_pkg::HeaderBytes);
		endfunction
	endclass
endpackage

// ===== tb/sv/testbench.sv =====
// Top-level testbench for first_fit_heap_allocator: directed and random requests
// under varied idling, checked against the shadow table. Depends on ffha_pkg,
// ffha_if, tb_heap_ledger_pkg and the RTL.
`timescale 1ns / 1ps
module testbench;
	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_we = 0;
	logic [15:0] cfg_data = 0;
	int          send_idle = 0;
	int          recv_stall = 0;
	bit          hold_off = 0;
	tb_heap_ledger_pkg::heap_ledger ledger;

	ffha_req_if req();
	ffha_rsp_if rsp();

	first_fit_heap_allocator u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.req(req.sink), .rsp(rsp.source)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// response side: random stalls plus one long hold-off
	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready)
			ledger.check_response(rsp.status, rsp.block_address, rsp.heap_empty);
		rsp.ready <= !hold_off && ($urandom_range(99) >= recv_stall);
	end

	task automatic send_request(logic op, logic [15:0] val);
		while (send_idle > 0 && $urandom_range(99) < send_idle) @(posedge clk);
		req.valid <= 1;
		req.op <= op;
		req.request_value <= val;
		do @(posedge clk); while (!req.ready);
		ledger.note_request(op, val);
		req.valid <= 0;
		// block is busy after accepting a request
		@(posedge clk);
	endtask

	task automatic drain();
		while (ledger.pending.size() > 0) @(posedge clk);
		repeat (3 * ffha_pkg::MaxBlocks + 20) @(posedge clk);
	endtask

	task automatic set_heap(logic [15:0] size);
		drain();
		cfg_we <= 1;
		cfg_data <= size;
		@(posedge clk);
		cfg_we <= 0;
		ledger.rebuild(size);
	endtask

	task automatic random_request();
		int pick;
		pick = $urandom_range(99);
		if (pick < 50)
			send_request(ffha_pkg::OP_ALLOC, ($urandom_range(9) == 0) ? 16'($urandom)
				: 16'($urandom_range(ledger.heap_bytes / 8 + 40)));
		else if (pick < 90)
			send_request(ffha_pkg::OP_FREE, ledger.live_address());
		else
			send_request(ffha_pkg::OP_FREE, 16'($urandom));
	endtask

	task automatic random_phase(int n, int idle, int stall);
		send_idle = idle;
		recv_stall = stall;
		repeat (n) random_request();
	endtask

	initial begin
		req.valid <= 0;
		req.op <= 0;
		req.request_value <= 0;
		ledger = new();
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: extremes, zero size, unknown free, no fit, table full
		send_request(ffha_pkg::OP_ALLOC, 16'd0);
		send_request(ffha_pkg::OP_ALLOC, 16'hFFFF);
		send_request(ffha_pkg::OP_FREE, 16'd16);
		send_request(ffha_pkg::OP_FREE, 16'd16);
		send_request(ffha_pkg::OP_FREE, 16'hFFFF);
		send_request(ffha_pkg::OP_ALLOC, 16'd49984);
		send_request(ffha_pkg::OP_ALLOC, 16'd0);
		send_request(ffha_pkg::OP_FREE, 16'd16);
		send_request(ffha_pkg::OP_ALLOC, 16'd49985);
		send_request(ffha_pkg::OP_ALLOC, 16'd49970);
		send_request(ffha_pkg::OP_FREE, 16'd16);
		repeat (ffha_pkg::MaxBlocks + 1) send_request(ffha_pkg::OP_ALLOC, 16'd1);
		set_heap(16'd16);
		send_request(ffha_pkg::OP_ALLOC, 16'd0);
		send_request(ffha_pkg::OP_ALLOC, 16'd1);
		send_request(ffha_pkg::OP_FREE, 16'd16);
		set_heap(16'hFFFF);
		send_request(ffha_pkg::OP_ALLOC, 16'd65000);
		send_request(ffha_pkg::OP_ALLOC, 16'd600);
		send_request(ffha_pkg::OP_ALLOC, 16'd200);
		random_phase(150, 0, 0);
		set_heap(16'd2000);
		random_phase(300, 56, 0);
		set_heap(16'd400);
		random_phase(300, 0, 56);
		set_heap(16'd50000);
		random_phase(300, 35, 35);
		// long receiver hold-off while requests keep coming
		fork
			begin
				hold_off = 1;
				repeat (400) @(posedge clk);
				hold_off = 0;
			end
			random_phase(20, 0, 0);
		join
		set_heap(16'd1000);
		random_phase(450, 0, 0);
		drain();
		if (ledger.errors == 0 && ledger.pending.size() == 0)
			$display("first_fit_heap_allocator test passed");
		else
			$display("first_fit_heap_allocator test failed");
		$finish;
	end

	initial begin
		#20ms;
		$display("first_fit_heap_allocator test failed");
		$finish;
	end
endmodule

// ===== files.f =====
rtl/ffha_pkg.sv
rtl/ffha_if.sv
rtl/ffha_datapath.sv
rtl/ffha_ctrl.sv
rtl/first_fit_heap_allocator.sv
tb/sv/tb_heap_ledger.sv
tb/sv/testbench.sv
